>>> hw/rtl/stif_pkg.sv
// ----------------------------------------------------------------------------
// stif_pkg: shared types, constants and arithmetic helpers
// Field widths, register indexes, reset values and the Q4.12 helpers used by
// the stereo sparse-tap IIR filter and its multiply-accumulate unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stif_pkg;

	// Sample and register layout
	localparam int SAMPLE_W   = 16;
	localparam int GAIN_W     = 16;
	localparam int WEIGHT_W   = 16;
	localparam int DELAY_W    = 12;
	localparam int TAP_W      = 28;
	localparam int FRAC_W     = 12;
	localparam int FRAME_W    = 2 * SAMPLE_W;

	// Configuration port
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 28;
	localparam int FF_REGS     = 4;
	localparam int FB_REGS     = 3;
	localparam int TAP_REGS    = FF_REGS + FB_REGS;
	localparam int TAP_SEL_W   = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_INPUT_GAIN = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FF_TAP0    = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FB_TAP0    = 4'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_COUNT      = 4'd8;

	localparam logic [GAIN_W-1:0] GAIN_RESET   = 16'd4096;
	localparam logic [TAP_W-1:0]  FF_TAP0_RESET = 28'd4096;
	localparam logic [TAP_W-1:0]  FF_TAP_RESET  = 28'd0;
	localparam logic [TAP_W-1:0]  FB_TAP_RESET  = 28'd65536;

	// Parameter defaults
	localparam int RING_FRAMES_DEF = 4096;
	localparam int NUM_FF_TAPS_DEF = 4;
	localparam int NUM_FB_TAPS_DEF = 3;

	// Multiplier operands: 16-bit sample times 17-bit signed factor
	localparam int FACTOR_W = GAIN_W + 1;
	localparam int PROD_W   = SAMPLE_W + FACTOR_W;
	localparam int TERM_W   = PROD_W - FRAC_W;
	localparam int ACC_W    = 24;

	localparam logic signed [PROD_W-1:0] ROUND_BIAS = (1 << FRAC_W) - 1;
	localparam logic signed [ACC_W-1:0]  SAT_MAX    = (1 << (SAMPLE_W - 1)) - 1;
	localparam logic signed [ACC_W-1:0]  SAT_MIN    = -(1 << (SAMPLE_W - 1));

	// Control of the shared multiply-accumulate unit
	typedef struct packed {
		logic clr;   // zero the accumulators
		logic mul;   // register a new product pair
		logic acc;   // add that product pair next cycle
	} mac_ctl_t;

	// Divide a Q4.12 product by 4096, truncating toward zero
	function automatic logic signed [TERM_W-1:0] trunc_q12(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] adj;
		adj = p + (p[PROD_W-1] ? ROUND_BIAS : '0);
		return adj[PROD_W-1:FRAC_W];
	endfunction

	// Clamp to the 16-bit sample range
	function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if (v > SAT_MAX) begin
			r = SAT_MAX[SAMPLE_W-1:0];
		end else if (v < SAT_MIN) begin
			r = SAT_MIN[SAMPLE_W-1:0];
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

	// Number of compare-subtract steps that bring a delay below the ring size
	function automatic int red_steps(input int n);
		int k;
		int s;
		k = 0;
		for (s = 0; s <= DELAY_W; s++) begin
			if ((n << k) < (1 << DELAY_W)) begin
				k++;
			end
		end
		return k;
	endfunction

endpackage

>>> hw/rtl/stif_if.sv
// ----------------------------------------------------------------------------
// stif_if: stream channels of the stereo filter
// Valid/ready channels for incoming stereo frames and filtered frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface stif_frame_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [stif_pkg::SAMPLE_W-1:0] left_in;
	logic signed [stif_pkg::SAMPLE_W-1:0] right_in;

	modport source (output valid, output left_in, output right_in, input ready);
	modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface stif_result_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [stif_pkg::SAMPLE_W-1:0] left_out;
	logic signed [stif_pkg::SAMPLE_W-1:0] right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

>>> hw/rtl/stif_ring.sv
// ----------------------------------------------------------------------------
// stif_ring: frame ring memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stif_ring #(
	parameter int  DEPTH = 4096,
	parameter int  DW    = 32,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/stif_mac.sv
// ----------------------------------------------------------------------------
// stif_mac: shared stereo multiply-accumulate unit
// Two 16x17 multipliers, Q4.12 truncation toward zero and 24-bit accumulators.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stif_mac (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  stif_pkg::mac_ctl_t                   ctl,
	input  logic signed [stif_pkg::SAMPLE_W-1:0] a_l,
	input  logic signed [stif_pkg::SAMPLE_W-1:0] a_r,
	input  logic signed [stif_pkg::FACTOR_W-1:0] b,
	output logic signed [stif_pkg::SAMPLE_W-1:0] scaled_l,
	output logic signed [stif_pkg::SAMPLE_W-1:0] scaled_r,
	output logic signed [stif_pkg::SAMPLE_W-1:0] sum_l,
	output logic signed [stif_pkg::SAMPLE_W-1:0] sum_r
);

	logic signed [stif_pkg::PROD_W-1:0] prod_l_s1;
	logic signed [stif_pkg::PROD_W-1:0] prod_r_s1;
	logic                               acc_s1;
	logic signed [stif_pkg::TERM_W-1:0] term_l;
	logic signed [stif_pkg::TERM_W-1:0] term_r;
	logic signed [stif_pkg::ACC_W-1:0]  acc_l_q;
	logic signed [stif_pkg::ACC_W-1:0]  acc_r_q;

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_l_s1 <= a_l * b;
			prod_r_s1 <= a_r * b;
		end
	end

	assign term_l = stif_pkg::trunc_q12(prod_l_s1);
	assign term_r = stif_pkg::trunc_q12(prod_r_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1  <= 1'b0;
			acc_l_q <= '0;
			acc_r_q <= '0;
		end else begin
			acc_s1 <= ctl.mul && ctl.acc;
			if (ctl.clr) begin
				acc_l_q <= '0;
				acc_r_q <= '0;
			end else if (acc_s1) begin
				acc_l_q <= acc_l_q + stif_pkg::ACC_W'(term_l);
				acc_r_q <= acc_r_q + stif_pkg::ACC_W'(term_r);
			end
		end
	end

	assign scaled_l = stif_pkg::sat16(stif_pkg::ACC_W'(term_l));
	assign scaled_r = stif_pkg::sat16(stif_pkg::ACC_W'(term_r));
	assign sum_l    = stif_pkg::sat16(acc_l_q);
	assign sum_r    = stif_pkg::sat16(acc_r_q);

endmodule

>>> hw/rtl/sparse_tap_iir_filter_stereo.sv
// ----------------------------------------------------------------------------
// sparse_tap_iir_filter_stereo: stereo IIR filter with sparse delay taps
// Each accepted request runs K reduction steps, a gain pass and T tap passes, where
//   T = NUM_FF_TAPS + NUM_FB_TAPS ring reads through the shared multiplier and
//   K = delay-reduction steps (0 when RING_FRAMES >= 4096).
// Frames are handled one at a time: a new one is accepted only in the idle state.
// Reset: registers take their reset values; a frame fill count makes unwritten
//   ring slots read as zero, so frames are accepted right after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sparse_tap_iir_filter_stereo #(
	parameter int RING_FRAMES = stif_pkg::RING_FRAMES_DEF,
	parameter int NUM_FF_TAPS = stif_pkg::NUM_FF_TAPS_DEF,
	parameter int NUM_FB_TAPS = stif_pkg::NUM_FB_TAPS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	stif_frame_if.sink                             audio,
	stif_result_if.source                          filtered,
	input  logic                                   cfg_write,
	input  logic [stif_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [stif_pkg::CFG_DATA_W-1:0]        cfg_data
);

	// Ring addressing: pointer of AW bits, fill count and index sums of AW+1
	localparam int AW       = $clog2(RING_FRAMES);
	localparam int NUM_TAPS = NUM_FF_TAPS + NUM_FB_TAPS;
	localparam int TSEL_W   = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
	localparam int IW       = (AW + 1 > stif_pkg::DELAY_W) ? AW + 1 : stif_pkg::DELAY_W;
	localparam int RSW      = stif_pkg::TAP_SEL_W;
	localparam int SW       = stif_pkg::SAMPLE_W;
	localparam int DW       = stif_pkg::DELAY_W;

	// Delay modulo ring size: restoring subtraction of RING_FRAMES << k
	localparam int RED_STEPS  = stif_pkg::red_steps(RING_FRAMES);
	localparam int STEP_W     = $clog2(RED_STEPS + 2);
	localparam int RED_TOP_I  = (RING_FRAMES << RED_STEPS) >> 1;
	localparam int RED_LAST_I = (RED_STEPS > 0) ? RED_STEPS - 1 : 0;
	localparam int TAP_LAST_I = NUM_TAPS - 1;
	localparam int RING_LAST_I = RING_FRAMES - 1;

	localparam logic [DW-1:0]     RED_TOP   = RED_TOP_I[DW-1:0];
	localparam logic [STEP_W-1:0] RED_LAST  = RED_LAST_I[STEP_W-1:0];
	localparam logic [TSEL_W-1:0] TAP_LAST  = TAP_LAST_I[TSEL_W-1:0];
	localparam logic [AW:0]       RING_N    = RING_FRAMES[AW:0];
	localparam logic [AW-1:0]     RING_LAST = RING_LAST_I[AW-1:0];

	typedef enum logic [2:0] {
		S_IDLE,
		S_REDUCE,
		S_GAIN,
		S_SCALE,
		S_TAPS,
		S_DRAIN,
		S_DONE
	} state_t;

	// Tap slot i maps to a feedforward register first, then to a feedback one
	function automatic logic [RSW-1:0] reg_of(input int i);
		int j;
		j = (i < NUM_FF_TAPS) ? i : stif_pkg::FF_REGS + i - NUM_FF_TAPS;
		return RSW'(j);
	endfunction

	// Configuration registers
	logic [stif_pkg::GAIN_W-1:0] gain_q;
	logic [stif_pkg::TAP_W-1:0]  tap_regs_q [stif_pkg::TAP_REGS];

	// Sequencer and result registers
	state_t                 state_q;
	logic [AW-1:0]          wp_q;
	logic [AW:0]            cnt_q;
	logic [TSEL_W-1:0]      tap_q;
	logic                   drain_q;
	logic [STEP_W-1:0]      step_q;
	logic                   rd_s1;
	logic                   out_valid_q;
	logic signed [SW-1:0]   out_l_q;
	logic signed [SW-1:0]   out_r_q;

	// Frame payload and read pipeline payload
	logic signed [SW-1:0]   samp_l_q;
	logic signed [SW-1:0]   samp_r_q;
	logic [DW-1:0]          red_q [NUM_TAPS];
	logic [DW-1:0]          red_sub_q;
	logic                   fb_s1;
	logic                   ok_s1;
	logic signed [stif_pkg::WEIGHT_W-1:0] weight_s1;

	// Handshake
	logic accept;
	logic slot_free;
	logic finish;

	// Tap read issue
	logic                   is_fb;
	logic [RSW-1:0]         rsel;
	logic [DW-1:0]          delay;
	logic [IW-1:0]          delay_ext;
	logic [AW:0]            delay_lo;
	logic [AW:0]            reach;
	logic [AW:0]            idx_sum;
	logic [AW:0]            idx;
	logic                   rd_issue;
	logic                   rd_ok;
	logic [AW-1:0]          rd_addr;

	// Rings
	logic                           in_we;
	logic                           out_we;
	logic [stif_pkg::FRAME_W-1:0]   in_rdata;
	logic [stif_pkg::FRAME_W-1:0]   out_rdata;
	logic [stif_pkg::FRAME_W-1:0]   ring_data;

	// Shared multiply-accumulate unit
	stif_pkg::mac_ctl_t                    mac_ctl;
	logic signed [SW-1:0]                  mac_a_l;
	logic signed [SW-1:0]                  mac_a_r;
	logic signed [stif_pkg::FACTOR_W-1:0]  mac_b;
	logic signed [SW-1:0]                  scaled_l;
	logic signed [SW-1:0]                  scaled_r;
	logic signed [SW-1:0]                  sum_l;
	logic signed [SW-1:0]                  sum_r;

	assign accept    = audio.valid && audio.ready;
	assign slot_free = !out_valid_q || filtered.ready;
	assign finish    = (state_q == S_DONE) && slot_free;

	assign audio.ready        = (state_q == S_IDLE);
	assign filtered.valid     = out_valid_q;
	assign filtered.left_out  = out_l_q;
	assign filtered.right_out = out_r_q;

	// Configuration writes; indexes past the register list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q        <= stif_pkg::GAIN_RESET;
			tap_regs_q[0] <= stif_pkg::FF_TAP0_RESET;
			for (int i = 1; i < stif_pkg::FF_REGS; i++) begin
				tap_regs_q[i] <= stif_pkg::FF_TAP_RESET;
			end
			for (int i = stif_pkg::FF_REGS; i < stif_pkg::TAP_REGS; i++) begin
				tap_regs_q[i] <= stif_pkg::FB_TAP_RESET;
			end
		end else if (cfg_write) begin
			if (cfg_index == stif_pkg::REG_INPUT_GAIN) begin
				gain_q <= cfg_data[stif_pkg::GAIN_W-1:0];
			end else if (cfg_index < stif_pkg::REG_COUNT) begin
				tap_regs_q[RSW'(cfg_index - stif_pkg::REG_FF_TAP0)] <= cfg_data;
			end
		end
	end

	// Tap read address: write pointer minus delay, wrapped into the ring.
	// A slot further back than the frames seen since reset reads as zero;
	// a feedback delay of zero reaches back a whole ring.
	assign is_fb     = (int'(tap_q) >= NUM_FF_TAPS);
	assign rsel      = reg_of(int'(tap_q));
	assign delay     = red_q[tap_q];
	assign delay_ext = IW'(delay);
	assign delay_lo  = delay_ext[AW:0];
	assign reach     = (is_fb && (delay == '0)) ? RING_N : delay_lo;
	assign idx_sum   = {1'b0, wp_q} + RING_N - delay_lo;
	assign idx       = (idx_sum >= RING_N) ? idx_sum - RING_N : idx_sum;
	assign rd_addr   = idx[AW-1:0];
	assign rd_ok     = (reach <= cnt_q);
	assign rd_issue  = (state_q == S_TAPS);

	assign in_we  = (state_q == S_SCALE);
	assign out_we = finish;

	stif_ring #(
		.DEPTH (RING_FRAMES),
		.DW    (stif_pkg::FRAME_W)
	) u_in_ring (
		.clk   (clk),
		.we    (in_we),
		.waddr (wp_q),
		.wdata ({scaled_r, scaled_l}),
		.re    (rd_issue),
		.raddr (rd_addr),
		.rdata (in_rdata)
	);

	stif_ring #(
		.DEPTH (RING_FRAMES),
		.DW    (stif_pkg::FRAME_W)
	) u_out_ring (
		.clk   (clk),
		.we    (out_we),
		.waddr (wp_q),
		.wdata ({sum_r, sum_l}),
		.re    (rd_issue),
		.raddr (rd_addr),
		.rdata (out_rdata)
	);

	// Feed the multiplier: gain pass first, then one ring sample per tap
	assign ring_data = fb_s1 ? out_rdata : in_rdata;

	always_comb begin
		mac_ctl.clr = (state_q == S_SCALE);
		mac_ctl.mul = (state_q == S_GAIN) || rd_s1;
		mac_ctl.acc = rd_s1;
		if (state_q == S_GAIN) begin
			mac_a_l = samp_l_q;
			mac_a_r = samp_r_q;
			mac_b   = signed'({1'b0, gain_q});
		end else begin
			mac_a_l = ok_s1 ? signed'(ring_data[SW-1:0]) : '0;
			mac_a_r = ok_s1 ? signed'(ring_data[2*SW-1:SW]) : '0;
			mac_b   = stif_pkg::FACTOR_W'(weight_s1);
		end
	end

	stif_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mac_ctl),
		.a_l      (mac_a_l),
		.a_r      (mac_a_r),
		.b        (mac_b),
		.scaled_l (scaled_l),
		.scaled_r (scaled_r),
		.sum_l    (sum_l),
		.sum_r    (sum_r)
	);

	// Sequencer: reduce delays, scale the frame, walk the taps, drain, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wp_q        <= '0;
			cnt_q       <= '0;
			tap_q       <= '0;
			drain_q     <= 1'b0;
			step_q      <= '0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
			out_l_q     <= '0;
			out_r_q     <= '0;
		end else begin
			rd_s1 <= rd_issue;
			// Load a new result, or drop the one just taken
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (filtered.valid && filtered.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						// Advance the write pointer before this frame is stored
						wp_q   <= (wp_q == RING_LAST) ? '0 : wp_q + 1'b1;
						step_q <= '0;
						state_q <= (RED_STEPS > 0) ? S_REDUCE : S_GAIN;
					end
				end
				S_REDUCE: begin
					step_q <= step_q + 1'b1;
					if (step_q == RED_LAST) begin
						state_q <= S_GAIN;
					end
				end
				S_GAIN: begin
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					tap_q   <= '0;
					state_q <= S_TAPS;
				end
				S_TAPS: begin
					if (tap_q == TAP_LAST) begin
						drain_q <= 1'b0;
						state_q <= S_DRAIN;
					end else begin
						tap_q <= tap_q + 1'b1;
					end
				end
				S_DRAIN: begin
					// Let the last product and then the last accumulate finish before S_DONE
					drain_q <= 1'b1;
					if (drain_q) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// Hold the result until the output register is free
					if (slot_free) begin
						out_l_q     <= sum_l;
						out_r_q     <= sum_r;
						cnt_q       <= (cnt_q == RING_N) ? cnt_q : cnt_q + 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload: frame samples, reduced delays and the read pipeline stage
	always_ff @(posedge clk) begin
		if (accept) begin
			samp_l_q  <= audio.left_in;
			samp_r_q  <= audio.right_in;
			red_sub_q <= RED_TOP;
			for (int i = 0; i < NUM_TAPS; i++) begin
				red_q[i] <= tap_regs_q[reg_of(i)][stif_pkg::TAP_W-1:stif_pkg::WEIGHT_W];
			end
		end else if (state_q == S_REDUCE) begin
			red_sub_q <= red_sub_q >> 1;
			for (int i = 0; i < NUM_TAPS; i++) begin
				if (red_q[i] >= red_sub_q) begin
					red_q[i] <= red_q[i] - red_sub_q;
				end
			end
		end
		if (rd_issue) begin
			fb_s1     <= is_fb;
			ok_s1     <= rd_ok;
			weight_s1 <= signed'(tap_regs_q[rsel][stif_pkg::WEIGHT_W-1:0]);
		end
	end

endmodule

>>> hw/rtl/stif_checker.sv
// ----------------------------------------------------------------------------
// stif_checker: port-level checks for the stereo sparse-tap filter
// Output handshake rules and the one-frame-at-a-time sequencing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stif_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [stif_pkg::SAMPLE_W-1:0] out_left,
	input logic signed [stif_pkg::SAMPLE_W-1:0] out_right
);

	logic in_acc;
	logic out_stall;

	assign in_acc    = in_valid && in_ready;
	assign out_stall = out_valid && !out_ready;

	// A waiting result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	// A waiting result keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_stall |=> ($stable(out_left) && $stable(out_right)))
		else $error("result changed while stalled");

	// Only one frame in work: no new request right after one is taken
	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("request accepted while a frame is in work");

	// A result never appears in the cycle after a request is taken
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_acc))
		else $error("result raised too early after request");

endmodule

bind sparse_tap_iir_filter_stereo stif_checker u_stif_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (audio.valid),
	.in_ready  (audio.ready),
	.out_valid (filtered.valid),
	.out_ready (filtered.ready),
	.out_left  (filtered.left_out),
	.out_right (filtered.right_out)
);
